// File: hw/rtl/strl_pkg.sv
// Shared types, constants and helpers for the string-to-long parser.
// No dependencies; used by every module of the block but the checker.
package strl_pkg;

    localparam int BASE_W = 5;
    localparam int POS_W  = 16;
    localparam int DIG_W  = 5;

    // Longest string the offset follows; the offset is clipped at the smaller
    // of this and what POS_W bits can hold.
    localparam longint MAX_STRING_LEN = 65535;
    localparam longint POS_FULL       = (longint'(1) << POS_W) - 1;
    localparam logic [POS_W-1:0] POS_CAP =
        POS_W'((MAX_STRING_LEN < POS_FULL) ? MAX_STRING_LEN : POS_FULL);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
    localparam logic [BASE_W-1:0] BASE_ONE   = BASE_W'(1);
    localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
    localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_RESET = BASE_DEC;

    localparam logic [DIG_W-1:0] DIGIT_NONE = DIG_W'(16);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [63:0] LIMIT_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_NEG_MAG = 64'h8000_0000_0000_0000;

    // queue between front and back
    localparam int Q_PTR_W = 2;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    // classified character
    typedef struct packed {
        logic [DIG_W-1:0] digit;   // 0..15, DIGIT_NONE if not a hex digit
        logic             is_ws;
        logic             is_minus;
        logic             is_plus;
        logic             is_zero;
        logic             is_x;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [63:0]      value;
        logic [POS_W-1:0] stop_offset;
        logic             saturated;
    } result_t;

    typedef enum logic [5:0] {
        PH_WS     = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_XSEEN  = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // base 1 behaves as decimal, anything above 16 as hex
    function automatic logic [BASE_W-1:0] norm_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b == BASE_ONE)
            r = BASE_DEC;
        else if (b > BASE_HEX)
            r = BASE_HEX;
        else
            r = b;
        return r;
    endfunction

endpackage

// File: hw/rtl/strl_front.sv
// Front end: classifies each incoming character byte.
// Depends on strl_pkg.
module strl_front (
    input  logic [7:0]    ch,
    input  logic          last,
    output strl_pkg::item_t item
);

    always_comb
    begin
        item          = '0;
        item.digit    = strl_pkg::DIGIT_NONE;
        item.last     = last;
        item.is_ws    = (ch == strl_pkg::CH_SPACE) ||
                        (ch inside {[strl_pkg::CH_TAB:strl_pkg::CH_CR]});
        item.is_minus = (ch == strl_pkg::CH_MINUS);
        item.is_plus  = (ch == strl_pkg::CH_PLUS);
        item.is_zero  = (ch == strl_pkg::CH_ZERO);
        item.is_x     = (ch == strl_pkg::CH_LX) || (ch == strl_pkg::CH_UX);
        if (ch inside {[strl_pkg::CH_ZERO:strl_pkg::CH_NINE]})
            item.digit = strl_pkg::DIG_W'(ch - strl_pkg::CH_ZERO);
        else if (ch inside {[strl_pkg::CH_LA:strl_pkg::CH_LF]})
            item.digit = strl_pkg::DIG_W'(ch - strl_pkg::CH_LA) + strl_pkg::DIG_W'(10);
        else if (ch inside {[strl_pkg::CH_UA:strl_pkg::CH_UF]})
            item.digit = strl_pkg::DIG_W'(ch - strl_pkg::CH_UA) + strl_pkg::DIG_W'(10);
    end

endmodule

// File: hw/rtl/strl_queue.sv
// Small FIFO of classified characters between front and back.
// Depends on strl_pkg.
module strl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  strl_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output strl_pkg::item_t head
);

    strl_pkg::item_t               mem_reg [strl_pkg::Q_DEPTH];
    logic [strl_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [strl_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [strl_pkg::Q_PTR_W:0]    count_reg, count_next;

    assign full      = (count_reg == (strl_pkg::Q_PTR_W + 1)'(strl_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: hw/rtl/strl_back.sv
// Back end: per-string parse state, digit accumulation with clipping and
// the registered result stage. Depends on strl_pkg.
module strl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [strl_pkg::BASE_W-1:0]   number_base,
    input  logic                          q_valid,
    input  strl_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          res_valid,
    input  logic                          res_ready,
    output strl_pkg::result_t             res
);

    strl_pkg::phase_t              phase_reg, phase_next;
    logic                          neg_reg, neg_next;
    logic [63:0]                   acc_reg, acc_next;
    logic [strl_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [strl_pkg::BASE_W-1:0]   base_reg, base_next;
    logic                          reported_reg, reported_next;
    logic                          clip_reg, clip_next;
    logic                          out_valid_reg;
    strl_pkg::result_t             out_reg, out_next;

    logic                          fresh;
    logic [strl_pkg::BASE_W-1:0]   base_cur;
    logic [strl_pkg::BASE_W-1:0]   dbase;
    logic                          dig_ok;
    logic [63:0]                   limit;
    logic [68:0]                   prod;
    logic                          ovf;
    logic [63:0]                   acc_dig;
    logic [strl_pkg::POS_W-1:0]    pos_inc;
    logic                          start;
    logic                          take;
    logic                          emit;
    logic                          conv;
    logic [strl_pkg::POS_W-1:0]    stop;
    logic [63:0]                   mag;

    // a new request may enter whenever the result stage is free or draining
    assign q_pop     = q_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        fresh    = (pos_reg == '0) && (phase_reg == strl_pkg::PH_WS) && !reported_reg;
        base_cur = fresh ? strl_pkg::norm_base(number_base) : base_reg;
        // automatic base not yet resolved only when a number starts; it is decimal then
        dbase    = (base_cur == strl_pkg::BASE_AUTO) ? strl_pkg::BASE_DEC : base_cur;
        dig_ok   = (q_item.digit < dbase);
        limit    = neg_reg ? strl_pkg::LIMIT_NEG_MAG : strl_pkg::LIMIT_POS;
        prod     = 69'(acc_reg) * 69'(dbase) + 69'(q_item.digit);
        ovf      = (prod > 69'(limit));
        acc_dig  = ovf ? limit : prod[63:0];
        pos_inc  = (pos_reg < strl_pkg::POS_CAP) ? pos_reg + strl_pkg::POS_ONE
                                                 : strl_pkg::POS_CAP;

        phase_next    = phase_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        base_next     = base_cur;
        clip_next     = clip_reg;
        reported_next = reported_reg;
        pos_next      = pos_inc;
        start         = 1'b0;
        take          = 1'b0;
        emit          = 1'b0;
        conv          = 1'b0;
        stop          = '0;

        case (phase_reg)
            strl_pkg::PH_WS:
            begin
                if (q_item.is_ws)
                begin
                    phase_next = strl_pkg::PH_WS;
                end
                else if (q_item.is_minus)
                begin
                    neg_next   = 1'b1;
                    phase_next = strl_pkg::PH_SIGN;
                end
                else if (q_item.is_plus)
                begin
                    phase_next = strl_pkg::PH_SIGN;
                end
                else
                begin
                    start = 1'b1;
                end
            end
            strl_pkg::PH_SIGN:
            begin
                start = 1'b1;
            end
            strl_pkg::PH_ZERO:
            begin
                if (q_item.is_x && (base_cur == strl_pkg::BASE_OCT ||
                                    base_cur == strl_pkg::BASE_HEX))
                begin
                    base_next  = strl_pkg::BASE_HEX;
                    phase_next = strl_pkg::PH_XSEEN;
                end
                else if (dig_ok)
                begin
                    take = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    conv = 1'b1;
                    stop = pos_reg;
                end
            end
            strl_pkg::PH_XSEEN:
            begin
                if (dig_ok)
                begin
                    take = 1'b1;
                end
                else
                begin
                    // dangling prefix: stop just after the '0'
                    emit = 1'b1;
                    conv = 1'b1;
                    stop = (pos_reg != '0) ? pos_reg - strl_pkg::POS_ONE : '0;
                end
            end
            strl_pkg::PH_DIGITS:
            begin
                if (dig_ok)
                begin
                    take = 1'b1;
                end
                else
                begin
                    emit = 1'b1;
                    conv = 1'b1;
                    stop = pos_reg;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (start)
        begin
            if (q_item.is_zero && (base_cur == strl_pkg::BASE_AUTO ||
                                   base_cur == strl_pkg::BASE_HEX))
            begin
                if (base_cur == strl_pkg::BASE_AUTO)
                    base_next = strl_pkg::BASE_OCT;
                phase_next = strl_pkg::PH_ZERO;
            end
            else
            begin
                base_next = dbase;
                if (dig_ok)
                    take = 1'b1;
                else
                    emit = 1'b1;
            end
        end

        if (take)
        begin
            acc_next   = acc_dig;
            clip_next  = clip_reg | ovf;
            phase_next = strl_pkg::PH_DIGITS;
        end

        if (emit)
        begin
            reported_next = 1'b1;
            phase_next    = strl_pkg::PH_DONE;
        end

        // end of string with no result yet
        if (q_item.last && !emit && !reported_reg)
        begin
            emit = 1'b1;
            if (phase_next == strl_pkg::PH_ZERO || phase_next == strl_pkg::PH_DIGITS)
            begin
                conv = 1'b1;
                stop = pos_inc;
            end
            else if (phase_next == strl_pkg::PH_XSEEN)
            begin
                conv = 1'b1;
                stop = (pos_inc != '0) ? pos_inc - strl_pkg::POS_ONE : '0;
            end
        end

        mag                  = conv ? acc_next : '0;
        out_next.value       = neg_next ? (64'd0 - mag) : mag;
        out_next.stop_offset = conv ? stop : '0;
        out_next.saturated   = conv & clip_next;

        if (q_item.last)
        begin
            phase_next    = strl_pkg::PH_WS;
            neg_next      = 1'b0;
            acc_next      = '0;
            pos_next      = '0;
            base_next     = strl_pkg::norm_base(number_base);
            reported_next = 1'b0;
            clip_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= strl_pkg::PH_WS;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            base_reg      <= strl_pkg::BASE_RESET;
            reported_reg  <= 1'b0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg    <= phase_next;
                neg_reg      <= neg_next;
                acc_reg      <= acc_next;
                pos_reg      <= pos_next;
                base_reg     <= base_next;
                reported_reg <= reported_next;
                clip_reg     <= clip_next;
            end
            if (q_pop && emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
            out_reg <= out_next;
    end

endmodule

// File: hw/rtl/string_to_long_parser.sv
// Top level of the streaming string-to-long parser: number base register,
// front classifier, queue and back end. Depends on strl_pkg and its submodules.
//
//  channel   direction  signals                         content
//  s_*       in         s_tvalid s_tready s_tdata s_tlast  one character, tlast on last
//  m_*       out        m_tvalid m_tready m_tdata       one result per string
//  cfg_*     in         cfg_wr_en cfg_wr_data           number base (0, 2..16)
//
// One character per cycle while m_tready allows; the back end does one
// multiply-by-base and add with a clip compare per cycle.
// A result is registered at the edge after the character that ends the parse is
// accepted, when the queue holds nothing older and the result stage is free.
// A four-entry queue lets input run on while the result stage is stalled.
// Reset clears all parse state and sets the number base to 10.
module string_to_long_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,     // [7:0] ch
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [87:0]                  m_tdata,     // [63:0] value, [79:64] stop_offset,
                                                      // [80] saturated, [87:81] zero
    input  logic                         cfg_wr_en,
    input  logic [strl_pkg::BASE_W-1:0]  cfg_wr_data
);

    logic [strl_pkg::BASE_W-1:0] number_base_reg;
    strl_pkg::item_t             front_item;
    strl_pkg::item_t             q_head;
    strl_pkg::result_t           res;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic                        push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            number_base_reg <= strl_pkg::BASE_RESET;
        else if (cfg_wr_en)
            number_base_reg <= cfg_wr_data;
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    strl_front u_front (
        .ch   (s_tdata),
        .last (s_tlast),
        .item (front_item)
    );

    strl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    strl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {7'd0, res.saturated, res.stop_offset, res.value};

endmodule

// File: hw/rtl/strl_checker.sv
// Port-level checks for string_to_long_parser, bound to the top level.
// Depends on the top level's port list only.
module strl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    // clipping only ever leaves one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[80] |->
            (m_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF) ||
            (m_tdata[63:0] == 64'h8000_0000_0000_0000))
        else $error("saturated result not at a limit");

    // every converted result stops past at least one character
    a_no_conv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[79:64] == 16'd0) |->
            (m_tdata[63:0] == 64'd0) && !m_tdata[80] && (m_tdata[87:81] == 7'd0))
        else $error("zero stop offset with non-empty result");

endmodule

bind string_to_long_parser strl_checker u_strl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/string_to_long_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for string_to_long_parser: streams characters, predicts one
// result per string and checks every result by field. Depends on strl_pkg.
module string_to_long_parser_tb;
    import strl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 125;
    localparam int N_PHASES    = 14;
    localparam int LONG_DIGITS = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_req_t;

    typedef struct {
        logic [63:0]      value;
        logic [POS_W-1:0] stop;
        logic             sat;
    } parse_result_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'h00;
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [87:0]         m_tdata;
    logic                cfg_wr_en   = 1'b0;
    logic [BASE_W-1:0]   cfg_wr_data = BASE_DEC;

    char_req_t     pending[$];
    parse_result_t expect_q[$];
    int            pushed_total   = 0;
    int            accepted_total = 0;
    int            errors         = 0;
    int            cycle_cnt      = 0;
    logic          char_taken     = 1'b0;
    bit            sender_steady  = 1'b0;
    bit            sink_steady    = 1'b0;
    int            hold_asked     = 0;

    // predictor state
    logic [BASE_W-1:0] base_reg     = BASE_RESET;
    logic [BASE_W-1:0] cur_radix    = BASE_RESET;
    phase_t            ph           = PH_WS;
    logic              str_neg      = 1'b0;
    logic [63:0]       acc          = '0;
    int                str_pos      = 0;
    logic              result_out   = 1'b0;
    logic              clipped_flag = 1'b0;

    string_to_long_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 clk = ~clk;

    function automatic logic [BASE_W-1:0] radix_of(input logic [BASE_W-1:0] b);
        if (b == BASE_ONE)
            return BASE_DEC;
        if (b > BASE_HEX)
            return BASE_HEX;
        return b;
    endfunction

    function automatic logic [DIG_W-1:0] digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return DIG_W'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF)
            return DIG_W'(c - CH_LA + 10);
        if (c >= CH_UA && c <= CH_UF)
            return DIG_W'(c - CH_UA + 10);
        return DIGIT_NONE;
    endfunction

    // multiply-add with clipping at the signed limit for the current sign
    function automatic bit take_digit(input logic [7:0] c);
        logic [DIG_W-1:0] d;
        logic [63:0]      lim;
        d = digit_value(c);
        if (cur_radix < 2 || d >= cur_radix)
            return 1'b0;
        lim = str_neg ? LIMIT_NEG_MAG : LIMIT_POS;
        if (acc > (lim - 64'(d)) / 64'(cur_radix))
        begin
            acc = lim;
            clipped_flag = 1'b1;
        end
        else
            acc = acc * 64'(cur_radix) + 64'(d);
        return 1'b1;
    endfunction

    function automatic void post_result(input bit conv, input int stop);
        parse_result_t r;
        logic [63:0]   m;
        m = conv ? acc : 64'd0;
        r.value = str_neg ? (64'd0 - m) : m;
        r.stop  = conv ? POS_W'(stop) : '0;
        r.sat   = conv ? clipped_flag : 1'b0;
        expect_q.push_back(r);
    endfunction

    function automatic void clear_string();
        ph           = PH_WS;
        str_neg      = 1'b0;
        acc          = '0;
        str_pos      = 0;
        cur_radix    = radix_of(base_reg);
        result_out   = 1'b0;
        clipped_flag = 1'b0;
    endfunction

    // first character after whitespace and sign
    function automatic bit begin_number(input logic [7:0] c);
        if (c == CH_ZERO && (cur_radix == BASE_AUTO || cur_radix == BASE_HEX))
        begin
            if (cur_radix == BASE_AUTO)
                cur_radix = BASE_OCT;
            ph = PH_ZERO;
            return 1'b0;
        end
        if (cur_radix == BASE_AUTO)
            cur_radix = BASE_DEC;
        if (take_digit(c))
        begin
            ph = PH_DIGITS;
            return 1'b0;
        end
        post_result(1'b0, 0);
        return 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic fin);
        int pos;
        bit hit;
        pos = str_pos;
        hit = 1'b0;
        if (pos == 0 && ph == PH_WS && !result_out)
            cur_radix = radix_of(base_reg);
        case (ph)
            PH_WS:
            begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                begin
                    if (c == CH_MINUS)
                    begin
                        str_neg = 1'b1;
                        ph = PH_SIGN;
                    end
                    else if (c == CH_PLUS)
                        ph = PH_SIGN;
                    else
                        hit = begin_number(c);
                end
            end
            PH_SIGN:
                hit = begin_number(c);
            PH_ZERO:
            begin
                if ((c == CH_LX || c == CH_UX) &&
                    (cur_radix == BASE_OCT || cur_radix == BASE_HEX))
                begin
                    cur_radix = BASE_HEX;
                    ph = PH_XSEEN;
                end
                else if (take_digit(c))
                    ph = PH_DIGITS;
                else
                begin
                    post_result(1'b1, pos);
                    hit = 1'b1;
                end
            end
            PH_XSEEN:
            begin
                // dangling prefix: stop just after the '0'
                if (take_digit(c))
                    ph = PH_DIGITS;
                else
                begin
                    post_result(1'b1, (pos > 0) ? pos - 1 : 0);
                    hit = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (!take_digit(c))
                begin
                    post_result(1'b1, pos);
                    hit = 1'b1;
                end
            end
            default: ;
        endcase
        if (hit)
        begin
            result_out = 1'b1;
            ph = PH_DONE;
        end
        str_pos = (pos < int'(POS_CAP)) ? pos + 1 : int'(POS_CAP);
        if (fin)
        begin
            if (!hit && !result_out)
            begin
                if (ph == PH_ZERO || ph == PH_DIGITS)
                    post_result(1'b1, str_pos);
                else if (ph == PH_XSEEN)
                    post_result(1'b1, (str_pos > 0) ? str_pos - 1 : 0);
                else
                    post_result(1'b0, 0);
            end
            clear_string();
        end
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // character sender
    always @(negedge clk)
    begin
        char_req_t nxt;
        int        gap_left;
        if (rst_n && (!s_tvalid || char_taken))
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (pending.size() != 0)
            begin
                nxt = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tlast  <= nxt.fin;
                gap_left = sender_steady ? 0 : idle_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver; a hold request stalls it for a long stretch
    always @(negedge clk)
    begin
        int hold_left;
        int hold_seen;
        int stall_left;
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (!sink_steady && $urandom_range(0, 3) == 0)
        begin
            stall_left = idle_len();
            m_tready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    // prediction on each accepted character, then result check
    always @(posedge clk)
    begin
        parse_result_t want;
        if (!rst_n)
            char_taken <= 1'b0;
        else
        begin
            char_taken <= s_tvalid && s_tready;
            if (cfg_wr_en)
                base_reg = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata, s_tlast);
                accepted_total <= accepted_total + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expect_q.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected result: expected none, ",
                              "got value %0d stop %0d sat %0b"},
                             $time, $signed(m_tdata[63:0]), m_tdata[79:64], m_tdata[80]);
                end
                else
                begin
                    want = expect_q.pop_front();
                    if (m_tdata[63:0] !== want.value)
                    begin
                        errors++;
                        $display("%0t: value mismatch: expected %0d, got %0d",
                                 $time, $signed(want.value), $signed(m_tdata[63:0]));
                    end
                    if (m_tdata[79:64] !== want.stop)
                    begin
                        errors++;
                        $display("%0t: stop_offset mismatch: expected %0d, got %0d",
                                 $time, want.stop, m_tdata[79:64]);
                    end
                    if (m_tdata[80] !== want.sat)
                    begin
                        errors++;
                        $display("%0t: saturated mismatch: expected %0b, got %0b",
                                 $time, want.sat, m_tdata[80]);
                    end
                    if (m_tdata[87:81] !== '0)
                    begin
                        errors++;
                        $display("%0t: padding mismatch: expected 0, got %0h",
                                 $time, m_tdata[87:81]);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_char(input logic [7:0] c, input logic fin);
        pending.push_back({c, fin});
        pushed_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], i == s.len() - 1);
    endtask

    task automatic random_string(input logic [BASE_W-1:0] b);
        logic [7:0] txt[$];
        int         n;
        int         k;
        int         d;
        int         radix;
        bit         auto_dec;
        radix    = radix_of(b);
        auto_dec = 1'b0;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 8);
            repeat (n) txt.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    k = $urandom_range(0, 5);
                    txt.push_back((k == 5) ? CH_SPACE : 8'(CH_TAB + k));
                end
            end
            case ($urandom_range(0, 3))
                0: txt.push_back(CH_MINUS);
                1: txt.push_back(CH_PLUS);
                default: ;
            endcase
            if (radix == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        txt.push_back(CH_ZERO);
                        txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                        radix = 16;
                    end
                    1:
                    begin
                        txt.push_back(CH_ZERO);
                        radix = 8;
                    end
                    default:
                    begin
                        radix = 10;
                        auto_dec = 1'b1;
                    end
                endcase
            end
            else if (radix == 16 && $urandom_range(0, 1) == 1)
            begin
                txt.push_back(CH_ZERO);
                txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            // a few long runs to reach the clipping limits
            if ($urandom_range(0, 9) == 0)
                n = (radix <= 4) ? $urandom_range(60, 70) : $urandom_range(15, 25);
            else
                n = $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0)
                n = 0;
            for (int i = 0; i < n; i++)
            begin
                d = (auto_dec && i == 0) ? $urandom_range(1, 9) : $urandom_range(0, radix - 1);
                if (d < 10)
                    txt.push_back(8'(CH_ZERO + d));
                else
                    txt.push_back(8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 4);
                repeat (n) txt.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (txt.size() == 0)
            txt.push_back(8'($urandom_range(0, 255)));
        foreach (txt[i])
            push_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_idle();
        while (accepted_total != pushed_total || expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_base(input logic [BASE_W-1:0] b);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= b;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int mark;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < N_PHASES; p++)
        begin
            logic [BASE_W-1:0] b;
            case (p)
                0:  b = BASE_RESET;
                1:  b = BASE_AUTO;
                2:  b = BASE_HEX;
                3:  b = BASE_W'(2);
                4:  b = BASE_OCT;
                5:  b = BASE_ONE;
                6:  b = BASE_W'(31);
                7:  b = BASE_W'(17);
                8:  b = BASE_AUTO;
                9:  b = BASE_HEX;
                10: b = BASE_DEC;
                default: b = BASE_W'($urandom_range(0, 31));
            endcase
            // the first phase runs on the reset value of the base
            if (p > 0)
                set_base(b);
            sender_steady = ($urandom_range(0, 4) == 0);
            sink_steady   = ($urandom_range(0, 4) == 0);
            if (p == 4)
            begin
                // receiver holds off while characters keep coming
                sender_steady = 1'b1;
                hold_asked++;
            end
            mark = pushed_total;
            case (p)
                0:
                begin
                    push_text("   +12");
                    push_char(CH_TAB, 1'b0);
                    push_char(8'h0A, 1'b0);
                    push_char(8'h0B, 1'b0);
                    push_char(8'h0C, 1'b0);
                    push_char(CH_CR, 1'b0);
                    push_text("-7");
                    push_text("abc");
                    push_text("12z34");
                    push_text("9223372036854775807");
                    push_text("9223372036854775808");
                    push_text("-9223372036854775808");
                    push_text("-99999999999999999999");
                    push_char(8'hFF, 1'b1);
                    push_char(8'h00, 1'b1);
                    push_text("-");
                    push_text("+ 5");
                    push_text("0");
                    push_text("077x");
                end
                1:
                begin
                    push_text("0x1f");
                    push_text("0X");
                    push_text("0xg");
                    push_text("017");
                    push_text("08");
                    push_text("-0x8000000000000000");
                    push_text("0x7FFFFFFFFFFFFFFFF");
                    push_text("42");
                end
                2:
                begin
                    push_text("0x");
                    push_text("0XfF");
                    push_text("0x ");
                    push_text("ABCDEF0123456789");
                end
                3:
                begin
                    push_text("1012");
                    push_text("-11");
                end
                5: push_text("19a");
                6: push_text("0x1G");
                default: ;
            endcase
            while (pushed_total - mark < PHASE_ITEMS)
                random_string(b);
            wait_idle();
        end

        // one long run of nines: the value stays pinned at the upper limit
        set_base(BASE_DEC);
        sender_steady = 1'b1;
        sink_steady   = 1'b0;
        repeat (LONG_DIGITS) push_char(CH_NINE, 1'b0);
        push_text("q");
        wait_idle();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
